### rtl/tolerant_run_length_encoder_top_assert.svh
// assertion macros used by the rle encoder top
`ifndef TOLERANT_RUN_LENGTH_ENCODER_TOP_ASSERT_SVH
`define TOLERANT_RUN_LENGTH_ENCODER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TRLE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("trle same-cycle check failed");

// antecedent implies consequent in the following cycle
`define TRLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("trle next-cycle check failed");

`endif

### rtl/trle_pkg.sv
`timescale 1ns / 1ps

package trle_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int TOL_WIDTH      = 17;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_TOLERANCE_ADDR = 3'd0;

   localparam logic [TOL_WIDTH-1:0] ONE_Q16 = 17'h10000;

   typedef struct packed {
      logic [31:0] value;
      logic        end_of_stream;
   } trle_req_type;

   typedef struct packed {
      logic [31:0] run_count;
      logic [31:0] run_value;
      logic        last_run;
      logic [31:0] mean_value;
   } trle_rsp_type;

endpackage

### rtl/tolerant_run_length_encoder_top.sv
// an item that opens a run is just stored; one that may join it is checked against
// both bounds and closes the run on a miss; end of stream adds the mean division
// throughput: one item at a time, set by the shared 32x32 multiplier (two bound
// products and one count*value product) and a 64-step restoring divider
// reset: synchronous, clears tolerance, the open run, sums and the output valid flag
`timescale 1ns / 1ps

`include "tolerant_run_length_encoder_top_assert.svh"

module tolerant_run_length_encoder_top
   import trle_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  trle_req_type              req_data,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output trle_rsp_type              rsp_data,

   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   localparam logic [63:0] VALUE_MAX = 64'((65'd1 << VALUE_WIDTH) - 65'd1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [5:0] DIV_LAST = 6'd63;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_LO,
      S_MUL_HI,
      S_CMP,
      S_CLOSE,
      S_ACCUM,
      S_FIN_MUL,
      S_FIN_SUM,
      S_DIV,
      S_FIN_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [TOL_WIDTH-1:0]   tol_ff, tol_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   eos_ff, eos_in;
   logic                   run_open_ff, run_open_in;
   logic [VALUE_WIDTH-1:0] open_value_ff, open_value_in;
   logic [COUNT_WIDTH-1:0] open_count_ff, open_count_in;
   logic [63:0]            wsum_ff, wsum_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [63:0]            prod_ff, prod_in;
   logic [48:0]            lo_ff, lo_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [5:0]             step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   trle_rsp_type           rsp_data_ff, rsp_data_in;

   logic [TOL_WIDTH-1:0]   tol_eff;
   logic [17:0]            fac_lo, fac_hi;
   logic [31:0]            mult_a, mult_b;
   logic [48:0]            ceil_p;
   logic [48:0]            v_ext;
   logic                   match;
   logic [COUNT_WIDTH-1:0] cnt_inc;
   logic [COUNT_WIDTH:0]   tot_sum;
   logic [COUNT_WIDTH-1:0] tot_sat;
   logic [64:0]            wsum_sum;
   logic [63:0]            wsum_sat;
   logic [COUNT_WIDTH:0]   rem_sh, div_diff;
   logic                   div_ge;
   logic [31:0]            mean;
   logic                   out_free;
   logic                   csr_write;
   logic                   mid_run_out;
   logic                   fin_done;
   logic                   final_out;

   // shared multiplier operand select
   assign tol_eff = (tol_ff > ONE_Q16) ? ONE_Q16 : tol_ff;
   assign fac_lo  = 18'(ONE_Q16) - 18'(tol_eff);
   assign fac_hi  = 18'(ONE_Q16) + 18'(tol_eff);
   assign mult_a  = 32'(open_value_ff);

   always_comb begin
      unique case (state_ff)
         S_MUL_LO: mult_b = 32'(fac_lo);
         S_MUL_HI: mult_b = 32'(fac_hi);
         default:  mult_b = 32'(open_count_ff);
      endcase
   end

   assign prod_in = 64'(mult_a) * 64'(mult_b);

   assign ceil_p = {1'b0, prod_ff[63:16]} + 49'(prod_ff[15:0] != 16'd0);
   assign v_ext  = 49'(value_ff);
   assign match  = (lo_ff <= v_ext) && (v_ext <= ceil_p);

   assign cnt_inc  = (open_count_ff == COUNT_MAX) ? COUNT_MAX : open_count_ff + COUNT_WIDTH'(1);
   assign tot_sum  = {1'b0, total_ff} + {1'b0, open_count_ff};
   assign tot_sat  = tot_sum[COUNT_WIDTH] ? COUNT_MAX : tot_sum[COUNT_WIDTH-1:0];
   assign wsum_sum = {1'b0, wsum_ff} + {1'b0, prod_ff};
   assign wsum_sat = wsum_sum[64] ? '1 : wsum_sum[63:0];

   // restoring divider step, quotient shifts into wsum
   assign rem_sh   = {rem_ff, wsum_ff[63]};
   assign div_ge   = rem_sh >= {1'b0, total_ff};
   assign div_diff = rem_sh - {1'b0, total_ff};

   assign mean = (wsum_ff > VALUE_MAX) ? VALUE_MAX[31:0] : wsum_ff[31:0];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_write = psel && penable && pwrite && (paddr == CSR_TOLERANCE_ADDR);

   always_comb begin
      state_in      = state_ff;
      tol_in        = csr_write ? pwdata[TOL_WIDTH-1:0] : tol_ff;
      value_in      = value_ff;
      eos_in        = eos_ff;
      run_open_in   = run_open_ff;
      open_value_in = open_value_ff;
      open_count_in = open_count_ff;
      wsum_in       = wsum_ff;
      total_in      = total_ff;
      lo_in         = lo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in = req_data.value[VALUE_WIDTH-1:0];
               eos_in   = req_data.end_of_stream;
               if (!run_open_ff) begin
                  run_open_in   = 1'b1;
                  open_value_in = req_data.value[VALUE_WIDTH-1:0];
                  open_count_in = COUNT_WIDTH'(1);
                  state_in      = req_data.end_of_stream ? S_FIN_MUL : S_IDLE;
               end else begin
                  state_in = S_MUL_LO;
               end
            end
         end
         S_MUL_LO: state_in = S_MUL_HI;
         S_MUL_HI: begin
            lo_in    = ceil_p;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (match) begin
               open_count_in = cnt_inc;
               state_in      = eos_ff ? S_FIN_MUL : S_IDLE;
            end else begin
               state_in = S_CLOSE;
            end
         end
         S_CLOSE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.run_count  = 32'(open_count_ff);
               rsp_data_in.run_value  = 32'(open_value_ff);
               rsp_data_in.last_run   = 1'b0;
               rsp_data_in.mean_value = 32'd0;
               state_in               = S_ACCUM;
            end
         end
         S_ACCUM: begin
            wsum_in       = wsum_sat;
            total_in      = tot_sat;
            open_value_in = value_ff;
            open_count_in = COUNT_WIDTH'(1);
            state_in      = eos_ff ? S_FIN_MUL : S_IDLE;
         end
         S_FIN_MUL: state_in = S_FIN_SUM;
         S_FIN_SUM: begin
            wsum_in  = wsum_sat;
            total_in = tot_sat;
            rem_in   = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in   = div_ge ? div_diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
            wsum_in  = {wsum_ff[62:0], div_ge};
            step_in  = step_ff + 6'd1;
            if (step_ff == DIV_LAST) begin
               state_in = S_FIN_OUT;
            end
         end
         S_FIN_OUT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.run_count  = 32'(open_count_ff);
               rsp_data_in.run_value  = 32'(open_value_ff);
               rsp_data_in.last_run   = 1'b1;
               rsp_data_in.mean_value = mean;
               run_open_in            = 1'b0;
               open_value_in          = '0;
               open_count_in          = '0;
               wsum_in                = '0;
               total_in               = '0;
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tol_ff        <= '0;
         run_open_ff   <= 1'b0;
         open_value_ff <= '0;
         open_count_ff <= '0;
         wsum_ff       <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tol_ff        <= tol_in;
         run_open_ff   <= run_open_in;
         open_value_ff <= open_value_in;
         open_count_ff <= open_count_in;
         wsum_ff       <= wsum_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      value_ff    <= value_in;
      eos_ff      <= eos_in;
      prod_ff     <= prod_in;
      lo_ff       <= lo_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr == CSR_TOLERANCE_ADDR) ? CSR_DATA_WIDTH'(tol_ff) : '0;

   assign mid_run_out = rsp_valid_ff && !rsp_data_ff.last_run;
   assign fin_done    = (state_ff == S_FIN_OUT) && out_free;
   assign final_out   = !run_open_ff && rsp_valid_ff && rsp_data_ff.last_run;

   `TRLE_ASSERT_SAME(a_open_run_counted, run_open_ff, open_count_ff != '0)
   `TRLE_ASSERT_SAME(a_divisor_nonzero, state_ff == S_DIV, total_ff != '0)
   `TRLE_ASSERT_SAME(a_mean_only_last, mid_run_out, rsp_data_ff.mean_value == 32'd0)
   `TRLE_ASSERT_NEXT(a_final_clears, fin_done, final_out)

endmodule
